>>> rtl/mpbm_pkg.sv
// Shared types and codes for the multi-pattern byte matcher.
package mpbm_pkg;

    localparam int SYM_W = 8;
    localparam int CNT_W = 16;
    localparam int TOT_W = 32;

    localparam logic [1:0] MODE_PATTERN = 2'd0;
    localparam logic [1:0] MODE_BUILD   = 2'd1;
    localparam logic [1:0] MODE_QUERY   = 2'd2;
    localparam logic [1:0] MODE_CLEAR   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_NOT_BUILT = 2'd2;

    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LATCH,
        OP_CLR,
        OP_PAT_RD,
        OP_PAT_UPD,
        OP_PAT_CNT,
        OP_Q_START,
        OP_Q_END,
        OP_Q_RD,
        OP_Q_CHK,
        OP_Q_ADD,
        OP_WALK_FAIL,
        OP_B_INIT,
        OP_B_RRD,
        OP_B_RCHK,
        OP_B_POP,
        OP_B_CUR,
        OP_B_FCUR,
        OP_B_CRD,
        OP_B_CCHK,
        OP_B_FRD,
        OP_B_FCHK,
        OP_B_SUM,
        OP_B_DONE
    } dp_op_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       last;
        logic       built;
        logic       clr_done;
        logic       goto_zero;
        logic       walk_more;
        logic       sym_last;
        logic       q_empty;
    } dp_stat_t;

endpackage

>>> rtl/multi_pattern_byte_matcher.sv
// Busy steps per item: a pattern byte reads and updates the goto memory, plus a count
// step with last; a query byte reads and checks, following fail links on a miss; a build
// scans the root's 256 symbols, then each queued node's 256 symbols, following fail links
// per child. One item at a time: start is taken again in the first cycle with busy low.
// Reset and a clear item sweep the goto memory with busy high.
// done pulses in the same cycle that busy drops; the receiver cannot stall the block.
module multi_pattern_byte_matcher
    import mpbm_pkg::*;
#(
    parameter int MAX_NODES = 512
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       mode,
    input  logic [SYM_W-1:0] data_byte,
    input  logic             last,
    output logic             done,
    output logic             result_kind,
    output logic [TOT_W-1:0] match_count,
    output logic [1:0]       status
);

    dp_op_t   op;
    dp_stat_t stat;

    mpbm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .op    (op)
    );

    mpbm_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .mode        (mode),
        .data_byte   (data_byte),
        .last        (last),
        .stat        (stat),
        .done        (done),
        .result_kind (result_kind),
        .match_count (match_count),
        .status      (status)
    );

endmodule

>>> rtl/mpbm_dp.sv
// Datapath: trie, fail links, node counts, BFS queue and result registers.
module mpbm_dp
    import mpbm_pkg::*;
#(
    parameter int MAX_NODES = 512
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_op_t             op,
    input  logic [1:0]         mode,
    input  logic [SYM_W-1:0]   data_byte,
    input  logic               last,
    output dp_stat_t           stat,
    output logic               done,
    output logic               result_kind,
    output logic [TOT_W-1:0]   match_count,
    output logic [1:0]         status
);

    localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int GW = NW + SYM_W;
    localparam int GDEPTH = MAX_NODES * (1 << SYM_W);
    localparam logic [GW-1:0] CLR_LAST = GW'(GDEPTH - 1);
    localparam logic [NW:0] MAX_W = (NW + 1)'(MAX_NODES);
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    logic [NW-1:0] goto_mem [GDEPTH];
    logic [NW-1:0] fail_mem [MAX_NODES];
    logic [CNT_W-1:0] cnt_mem [MAX_NODES];
    logic [NW-1:0] queue_mem [MAX_NODES];

    logic [1:0]       mode_reg;
    logic [SYM_W-1:0] byte_reg;
    logic             last_reg;
    logic             built_reg, ovf_reg;
    logic [NW:0]      used_reg;
    logic [NW-1:0]    ins_reg, mcur_reg;
    logic [TOT_W-1:0] total_reg;
    logic [GW-1:0]    clr_reg;
    logic [NW-1:0]    node_reg, cur_reg, fcur_reg, child_reg;
    logic [SYM_W-1:0] sym_reg;
    logic [NW:0]      steps_reg, head_reg, tail_reg;
    logic [NW-1:0]    gdat_reg, fdat_reg, qdat_reg;
    logic [CNT_W-1:0] cnta_reg, cntb_reg;
    logic             done_reg, kind_reg;
    logic [TOT_W-1:0] count_reg;
    logic [1:0]       status_reg;

    logic [GW-1:0]    g_ra, g_wa;
    logic             g_we;
    logic [NW-1:0]    g_wd;
    logic [NW-1:0]    f_ra, f_wa, f_wd;
    logic             f_we;
    logic             q_we;
    logic [NW-1:0]    q_wd;
    logic [NW-1:0]    c_ra, c_wa;
    logic             c_we;
    logic [CNT_W-1:0] c_wd;

    logic             walk_more, can_alloc, can_push;
    logic [NW-1:0]    pat_nxt, q_nxt;
    logic [CNT_W:0]   cnt_sum;
    logic [TOT_W:0]   tot_sum;
    logic [TOT_W-1:0] tot_sat;
    logic [1:0]       ovf_status;

    assign walk_more  = (node_reg != '0) && (gdat_reg == '0) && (steps_reg < MAX_W);
    assign can_alloc  = used_reg < MAX_W;
    assign can_push   = tail_reg < MAX_W;
    assign pat_nxt    = (gdat_reg != '0) ? gdat_reg :
                        (can_alloc ? used_reg[NW-1:0] : '0);
    assign q_nxt      = (gdat_reg != '0) ? gdat_reg : node_reg;
    assign cnt_sum    = {1'b0, cnta_reg} + {1'b0, cntb_reg};
    assign tot_sum    = {1'b0, total_reg} + {{(TOT_W-CNT_W+1){1'b0}}, cnta_reg};
    assign tot_sat    = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
    assign ovf_status = ovf_reg ? ST_OVERFLOW : ST_OK;

    always_comb
    begin
        g_ra = {ins_reg, byte_reg};
        g_we = 1'b0;
        g_wa = {ins_reg, byte_reg};
        g_wd = pat_nxt;
        f_ra = node_reg;
        f_we = 1'b0;
        f_wa = child_reg;
        f_wd = gdat_reg;
        q_we = 1'b0;
        q_wd = gdat_reg;
        c_ra = ins_reg;
        c_we = 1'b0;
        c_wa = child_reg;
        c_wd = cnt_sum[CNT_W] ? CNT_MAX : cnt_sum[CNT_W-1:0];
        unique case (op)
            OP_CLR:
            begin
                g_we = 1'b1;
                g_wa = clr_reg;
                g_wd = '0;
                c_we = clr_reg < GW'(MAX_NODES);
                c_wa = clr_reg[NW-1:0];
                c_wd = '0;
            end
            OP_PAT_UPD:
            begin
                g_we = (gdat_reg == '0) && can_alloc;
                c_ra = (pat_nxt != '0) ? pat_nxt : ins_reg;
            end
            OP_PAT_CNT:
            begin
                c_we = 1'b1;
                c_wa = ins_reg;
                c_wd = (cnta_reg == CNT_MAX) ? CNT_MAX : cnta_reg + CNT_W'(1);
            end
            OP_Q_RD:  g_ra = {node_reg, byte_reg};
            OP_Q_CHK: c_ra = q_nxt;
            OP_B_INIT:
            begin
                f_we = 1'b1;
                f_wa = '0;
                f_wd = '0;
            end
            OP_B_RRD: g_ra = {{NW{1'b0}}, sym_reg};
            OP_B_RCHK:
            begin
                f_we = (gdat_reg != '0) && can_push;
                f_wa = gdat_reg;
                f_wd = '0;
                q_we = (gdat_reg != '0) && can_push;
            end
            OP_B_CUR:  f_ra = qdat_reg;
            OP_B_CRD:  g_ra = {cur_reg, sym_reg};
            OP_B_FRD:  g_ra = {node_reg, sym_reg};
            OP_B_FCHK:
            begin
                f_we = !walk_more;
                q_we = !walk_more && can_push;
                q_wd = child_reg;
                c_ra = child_reg;
            end
            OP_B_SUM: c_we = 1'b1;
            default: ;
        endcase
    end

    // Memories: one write port, registered reads.
    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            goto_mem[g_wa] <= g_wd;
        end
        gdat_reg <= goto_mem[g_ra];
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            fail_mem[f_wa] <= f_wd;
        end
        fdat_reg <= fail_mem[f_ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[tail_reg[NW-1:0]] <= q_wd;
        end
        qdat_reg <= queue_mem[head_reg[NW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
        begin
            cnt_mem[c_wa] <= c_wd;
        end
        cnta_reg <= cnt_mem[c_ra];
        cntb_reg <= cnt_mem[gdat_reg];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            built_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            used_reg  <= (NW + 1)'(1);
            ins_reg   <= '0;
            mcur_reg  <= '0;
            total_reg <= '0;
            clr_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            steps_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (op)
                OP_CLR:
                begin
                    clr_reg   <= (clr_reg == CLR_LAST) ? '0 : clr_reg + GW'(1);
                    built_reg <= 1'b0;
                    ovf_reg   <= 1'b0;
                    used_reg  <= (NW + 1)'(1);
                    ins_reg   <= '0;
                    mcur_reg  <= '0;
                    total_reg <= '0;
                end
                OP_PAT_UPD:
                begin
                    if ((gdat_reg == '0) && can_alloc)
                    begin
                        used_reg <= used_reg + (NW + 1)'(1);
                    end
                    if ((gdat_reg == '0) && !can_alloc)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    if (pat_nxt != '0)
                    begin
                        ins_reg <= pat_nxt;
                    end
                end
                OP_PAT_CNT: ins_reg <= '0;
                OP_Q_START: steps_reg <= '0;
                OP_Q_END:
                begin
                    done_reg  <= 1'b1;
                    mcur_reg  <= '0;
                    total_reg <= '0;
                end
                OP_Q_CHK:
                begin
                    if (!walk_more)
                    begin
                        mcur_reg <= q_nxt;
                    end
                end
                OP_Q_ADD:
                begin
                    if (last_reg)
                    begin
                        done_reg  <= 1'b1;
                        mcur_reg  <= '0;
                        total_reg <= '0;
                    end
                    else
                    begin
                        total_reg <= tot_sat;
                    end
                end
                OP_WALK_FAIL: steps_reg <= steps_reg + (NW + 1)'(1);
                OP_B_INIT:
                begin
                    ins_reg  <= '0;
                    head_reg <= '0;
                    tail_reg <= '0;
                end
                OP_B_RCHK:
                begin
                    if ((gdat_reg != '0) && can_push)
                    begin
                        tail_reg <= tail_reg + (NW + 1)'(1);
                    end
                end
                OP_B_POP: head_reg <= head_reg + (NW + 1)'(1);
                OP_B_CCHK: steps_reg <= '0;
                OP_B_FCHK:
                begin
                    if (!walk_more && can_push)
                    begin
                        tail_reg <= tail_reg + (NW + 1)'(1);
                    end
                end
                OP_B_DONE:
                begin
                    ins_reg   <= '0;
                    built_reg <= 1'b1;
                    done_reg  <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Item latch, walk registers and result payload.
    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LATCH:
            begin
                mode_reg <= mode;
                byte_reg <= data_byte;
                last_reg <= last;
            end
            OP_Q_START: node_reg <= mcur_reg;
            OP_Q_END:
            begin
                kind_reg   <= KIND_QUERY;
                count_reg  <= '0;
                status_reg <= ST_NOT_BUILT;
            end
            OP_Q_CHK:
            begin
                if (!walk_more)
                begin
                    node_reg <= q_nxt;
                end
            end
            OP_Q_ADD:
            begin
                kind_reg   <= KIND_QUERY;
                count_reg  <= tot_sat;
                status_reg <= ovf_status;
            end
            OP_WALK_FAIL: node_reg <= fdat_reg;
            OP_B_INIT: sym_reg <= '0;
            OP_B_RCHK: sym_reg <= sym_reg + SYM_W'(1);
            OP_B_CUR: cur_reg <= qdat_reg;
            OP_B_FCUR:
            begin
                fcur_reg <= fdat_reg;
                sym_reg  <= '0;
            end
            OP_B_CCHK:
            begin
                if (gdat_reg == '0)
                begin
                    sym_reg <= sym_reg + SYM_W'(1);
                end
                else
                begin
                    child_reg <= gdat_reg;
                    node_reg  <= fcur_reg;
                end
            end
            OP_B_SUM: sym_reg <= sym_reg + SYM_W'(1);
            OP_B_DONE:
            begin
                kind_reg   <= KIND_BUILD;
                count_reg  <= '0;
                status_reg <= ovf_status;
            end
            default: ;
        endcase
    end

    assign stat.mode      = mode_reg;
    assign stat.last      = last_reg;
    assign stat.built     = built_reg;
    assign stat.clr_done  = clr_reg == CLR_LAST;
    assign stat.goto_zero = gdat_reg == '0;
    assign stat.walk_more = walk_more;
    assign stat.sym_last  = sym_reg == {SYM_W{1'b1}};
    assign stat.q_empty   = head_reg == tail_reg;

    assign done        = done_reg;
    assign result_kind = kind_reg;
    assign match_count = count_reg;
    assign status      = status_reg;

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= MAX_W)
        else $error("node allocation ran past the trie size");
    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("BFS queue head passed its tail");
    a_build_count: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (kind_reg == KIND_BUILD) |-> (count_reg == '0)
            && (status_reg != ST_NOT_BUILT))
        else $error("build beat carries a count or not-built status");
    a_not_built: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (status_reg == ST_NOT_BUILT) |-> (count_reg == '0)
            && (kind_reg == KIND_QUERY))
        else $error("not-built beat carries a count");
    a_built_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) && (kind_reg == KIND_BUILD) |-> built_reg)
        else $error("build beat without a built automaton");
`endif

endmodule

>>> rtl/mpbm_ctrl.sv
// Controller: sequences clear, insert, build and query steps on the datapath.
module mpbm_ctrl
    import mpbm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output logic     busy,
    output dp_op_t   op
);

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DISP,
        S_PAT_RD,
        S_PAT_UPD,
        S_PAT_CNT,
        S_Q_RD,
        S_Q_CHK,
        S_Q_FAIL,
        S_Q_ADD,
        S_B_RRD,
        S_B_RCHK,
        S_B_POP,
        S_B_CUR,
        S_B_FCUR,
        S_B_CRD,
        S_B_CCHK,
        S_B_FRD,
        S_B_FCHK,
        S_B_FSTEP,
        S_B_SUM
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_IDLE;
        unique case (state_reg)
            S_CLR:
            begin
                op = OP_CLR;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op         = OP_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.mode)
                    MODE_PATTERN: state_next = stat.built ? S_IDLE : S_PAT_RD;
                    MODE_BUILD:
                    begin
                        if (stat.built)
                        begin
                            op         = OP_B_DONE;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            op         = OP_B_INIT;
                            state_next = S_B_RRD;
                        end
                    end
                    MODE_QUERY:
                    begin
                        if (stat.built)
                        begin
                            op         = OP_Q_START;
                            state_next = S_Q_RD;
                        end
                        else
                        begin
                            op         = stat.last ? OP_Q_END : OP_IDLE;
                            state_next = S_IDLE;
                        end
                    end
                    MODE_CLEAR: state_next = S_CLR;
                    default: state_next = S_IDLE;
                endcase
            end
            S_PAT_RD:
            begin
                op         = OP_PAT_RD;
                state_next = S_PAT_UPD;
            end
            S_PAT_UPD:
            begin
                op         = OP_PAT_UPD;
                state_next = stat.last ? S_PAT_CNT : S_IDLE;
            end
            S_PAT_CNT:
            begin
                op         = OP_PAT_CNT;
                state_next = S_IDLE;
            end
            S_Q_RD:
            begin
                op         = OP_Q_RD;
                state_next = S_Q_CHK;
            end
            S_Q_CHK:
            begin
                op         = OP_Q_CHK;
                state_next = stat.walk_more ? S_Q_FAIL : S_Q_ADD;
            end
            S_Q_FAIL:
            begin
                op         = OP_WALK_FAIL;
                state_next = S_Q_RD;
            end
            S_Q_ADD:
            begin
                op         = OP_Q_ADD;
                state_next = S_IDLE;
            end
            S_B_RRD:
            begin
                op         = OP_B_RRD;
                state_next = S_B_RCHK;
            end
            S_B_RCHK:
            begin
                op         = OP_B_RCHK;
                state_next = stat.sym_last ? S_B_POP : S_B_RRD;
            end
            S_B_POP:
            begin
                if (stat.q_empty)
                begin
                    op         = OP_B_DONE;
                    state_next = S_IDLE;
                end
                else
                begin
                    op         = OP_B_POP;
                    state_next = S_B_CUR;
                end
            end
            S_B_CUR:
            begin
                op         = OP_B_CUR;
                state_next = S_B_FCUR;
            end
            S_B_FCUR:
            begin
                op         = OP_B_FCUR;
                state_next = S_B_CRD;
            end
            S_B_CRD:
            begin
                op         = OP_B_CRD;
                state_next = S_B_CCHK;
            end
            S_B_CCHK:
            begin
                op = OP_B_CCHK;
                if (!stat.goto_zero)
                begin
                    state_next = S_B_FRD;
                end
                else
                begin
                    state_next = stat.sym_last ? S_B_POP : S_B_CRD;
                end
            end
            S_B_FRD:
            begin
                op         = OP_B_FRD;
                state_next = S_B_FCHK;
            end
            S_B_FCHK:
            begin
                op         = OP_B_FCHK;
                state_next = stat.walk_more ? S_B_FSTEP : S_B_SUM;
            end
            S_B_FSTEP:
            begin
                op         = OP_WALK_FAIL;
                state_next = S_B_FRD;
            end
            S_B_SUM:
            begin
                op         = OP_B_SUM;
                state_next = stat.sym_last ? S_B_POP : S_B_CRD;
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");
    a_dispatch_follows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DISP |-> $past(state_reg) == S_IDLE)
        else $error("dispatch entered without an accepted beat");
    a_fail_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_Q_FAIL) || (state_reg == S_B_FSTEP) |->
            $past(stat.walk_more))
        else $error("fail link followed without a miss");
`endif

endmodule

>>> sim/mpbm_checker.sv
// Checker for the multi-pattern byte matcher: tracks the trie, predicts results, compares.
`timescale 1ns / 100ps
module mpbm_checker
    import mpbm_pkg::*;
#(
    parameter int MAX_NODES = 512
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [1:0]       mode,
    input  logic [SYM_W-1:0] data_byte,
    input  logic             last,
    input  logic             done,
    input  logic             result_kind,
    input  logic [TOT_W-1:0] match_count,
    input  logic [1:0]       status,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic             kind;
        logic [TOT_W-1:0] total;
        logic [1:0]       st;
    } match_result_t;

    match_result_t result_q[$];

    int               child_tab [MAX_NODES*256];
    int               fail_tab  [MAX_NODES];
    logic [CNT_W-1:0] hits_tab  [MAX_NODES];
    int               walk_q    [MAX_NODES];
    int               node_cnt;
    int               ins_node;
    int               cur_node;
    logic [TOT_W-1:0] total_acc;
    logic             is_built;
    logic             is_full;
    int               n_err;

    function automatic int child(int node, int sym);
        return child_tab[(node % MAX_NODES) * 256 + sym];
    endfunction

    // Append one expected beat at the tail of the queue.
    function automatic void enqueue_result(match_result_t r);
        result_q = {result_q, r};
    endfunction

    function automatic void wipe_trie();
        foreach (child_tab[i]) child_tab[i] = 0;
        foreach (fail_tab[i]) fail_tab[i] = 0;
        foreach (hits_tab[i]) hits_tab[i] = '0;
        node_cnt  = 1;
        ins_node  = 0;
        cur_node  = 0;
        total_acc = '0;
        is_built  = 1'b0;
        is_full   = 1'b0;
    endfunction

    function automatic void grow_trie(int sym, logic fin);
        int nxt;
        nxt = child(ins_node, sym);
        if (nxt == 0)
        begin
            if (node_cnt < MAX_NODES)
            begin
                nxt = node_cnt;
                node_cnt++;
                child_tab[ins_node * 256 + sym] = nxt;
            end
            else
                is_full = 1'b1;
        end
        if (nxt != 0)
            ins_node = nxt;
        if (fin)
        begin
            if (hits_tab[ins_node] != '1)
                hits_tab[ins_node]++;
            ins_node = 0;
        end
    endfunction

    function automatic void link_trie();
        int head;
        int tail;
        int node;
        int c;
        int f;
        int tgt;
        int steps;
        logic [CNT_W:0] sum;
        head = 0;
        tail = 0;
        fail_tab[0] = 0;
        for (int s = 0; s < 256; s++)
        begin
            c = child(0, s);
            if (c != 0 && tail < MAX_NODES)
            begin
                fail_tab[c] = 0;
                walk_q[tail++] = c;
            end
        end
        while (head < tail)
        begin
            node = walk_q[head++];
            for (int s = 0; s < 256; s++)
            begin
                c = child(node, s);
                if (c != 0)
                begin
                    f = fail_tab[node % MAX_NODES];
                    steps = 0;
                    while (f != 0 && child(f, s) == 0 && steps < MAX_NODES)
                    begin
                        f = fail_tab[f % MAX_NODES];
                        steps++;
                    end
                    tgt = child(f, s);
                    fail_tab[c] = tgt;
                    sum = hits_tab[c] + hits_tab[tgt];
                    hits_tab[c] = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
                    if (tail < MAX_NODES)
                        walk_q[tail++] = c;
                end
            end
        end
        is_built = 1'b1;
    endfunction

    function automatic void scan_byte(int sym);
        int node;
        int steps;
        int nxt;
        logic [TOT_W:0] sum;
        node = cur_node;
        steps = 0;
        while (node != 0 && child(node, sym) == 0 && steps < MAX_NODES)
        begin
            node = fail_tab[node % MAX_NODES];
            steps++;
        end
        nxt = child(node, sym);
        if (nxt != 0)
            node = nxt;
        cur_node = node;
        sum = total_acc + hits_tab[node];
        total_acc = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
    endfunction

    function automatic void note_error(string what, match_result_t want);
        n_err++;
        if (n_err <= 10)
            $display({"%t mismatch (%s): expected kind=%0d count=%0d status=%0d,",
                      " got kind=%0d count=%0d status=%0d"},
                     $realtime, what, want.kind, want.total, want.st,
                     result_kind, match_count, status);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        match_result_t want;
        if (!rst_n)
        begin
            wipe_trie();
            result_q.delete();
            n_err = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            // Compare the finished beat before predicting from a new one.
            if (done)
            begin
                if (result_q.size() == 0)
                begin
                    want = '0;
                    note_error("no result expected", want);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (result_kind !== want.kind || match_count !== want.total
                        || status !== want.st)
                        note_error("field", want);
                end
            end
            if (start && !busy)
            begin
                case (mode)
                    MODE_PATTERN:
                        if (!is_built)
                            grow_trie(data_byte, last);
                    MODE_BUILD:
                    begin
                        ins_node = 0;
                        if (!is_built)
                            link_trie();
                        want = '{KIND_BUILD, '0, is_full ? ST_OVERFLOW : ST_OK};
                        enqueue_result(want);
                    end
                    MODE_QUERY:
                    begin
                        if (is_built)
                            scan_byte(data_byte);
                        if (last)
                        begin
                            if (is_built)
                                want = '{KIND_QUERY, total_acc,
                                         is_full ? ST_OVERFLOW : ST_OK};
                            else
                                want = '{KIND_QUERY, '0, ST_NOT_BUILT};
                            enqueue_result(want);
                            cur_node = 0;
                            total_acc = '0;
                        end
                    end
                    default:
                        wipe_trie();
                endcase
            end
            fail_count <= n_err;
            pending <= result_q.size();
        end
    end

endmodule

>>> sim/multi_pattern_byte_matcher_tb.sv
// Testbench top for the multi-pattern byte matcher: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module multi_pattern_byte_matcher_tb;
    import mpbm_pkg::*;

    localparam int MAX_NODES = 512;
    localparam int QUIET_LIMIT = 1500000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [1:0]       mode = MODE_PATTERN;
    logic [SYM_W-1:0] data_byte = '0;
    logic             last = 1'b0;
    logic             done;
    logic             result_kind;
    logic [TOT_W-1:0] match_count;
    logic [1:0]       status;
    int               fail_count;
    int               pending;
    int               quiet = 0;
    logic             idle_on = 1'b1;
    logic [7:0]       pat_log[$];
    logic [7:0]       alpha[4];

    multi_pattern_byte_matcher #(.MAX_NODES(MAX_NODES)) dut (.*);

    mpbm_checker #(.MAX_NODES(MAX_NODES)) chk (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("multi_pattern_byte_matcher_tb: FAIL");
                $finish;
            end
        end
    end

    // Drive one beat and hold it until the block takes it.
    task automatic send(input logic [1:0] m, input logic [7:0] b, input logic l);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        start <= 1'b1;
        mode <= m;
        data_byte <= b;
        last <= l;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic send_str(input logic [1:0] m, input string s);
        for (int i = 0; i < s.len(); i++)
            send(m, s[i], i == s.len() - 1);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_sym();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return alpha[$urandom_range(0, 3)];
    endfunction

    initial
    begin
        int len;
        int idx;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: query before build, classic pattern set, extremes.
        send(MODE_QUERY, 8'h61, 1'b0);
        send(MODE_QUERY, 8'h62, 1'b1);
        send_str(MODE_PATTERN, "he");
        send_str(MODE_PATTERN, "she");
        send_str(MODE_PATTERN, "hers");
        send_str(MODE_PATTERN, "he");
        send(MODE_PATTERN, 8'h00, 1'b1);
        send(MODE_PATTERN, 8'hFF, 1'b1);
        send(MODE_PATTERN, 8'h68, 1'b0);
        send(MODE_BUILD, 8'h00, 1'b0);
        send(MODE_BUILD, 8'hFF, 1'b1);
        send(MODE_PATTERN, 8'h73, 1'b1);
        send_str(MODE_QUERY, "ushers");
        send(MODE_QUERY, 8'hFF, 1'b0);
        send(MODE_QUERY, 8'h00, 1'b0);
        send(MODE_QUERY, 8'hFF, 1'b1);
        drain();
        send(MODE_CLEAR, 8'hA5, 1'b1);

        // Fill the trie past its capacity with long random patterns.
        len = 0;
        for (int i = 0; i < 620; i++)
        begin
            logic [7:0] b;
            b = 8'($urandom_range(0, 255));
            if (len == 0)
                len = $urandom_range(1, 40);
            len--;
            pat_log.push_front(b);
            send(MODE_PATTERN, b, len == 0);
        end
        send(MODE_PATTERN, 8'h5A, 1'b1);
        send(MODE_BUILD, 8'h00, 1'b0);
        for (int q = 0; q < 20; q++)
        begin
            // The log runs newest first; walk it backward to replay a stretch.
            len = $urandom_range(1, 12);
            idx = $urandom_range(len - 1, pat_log.size() - 1);
            for (int i = 0; i < len; i++)
                send(MODE_QUERY, pat_log[idx - i], i == len - 1 && q[0]);
            if (!q[0])
                send(MODE_QUERY, 8'($urandom_range(0, 255)), 1'b1);
        end
        drain();
        send(MODE_CLEAR, 8'h00, 1'b0);

        // Small alphabet so that patterns overlap and fail links get deep.
        alpha[0] = 8'h41;
        alpha[1] = 8'h42;
        alpha[2] = 8'h43;
        alpha[3] = 8'($urandom_range(0, 255));
        send(MODE_QUERY, pick_sym(), 1'b1);
        for (int p = 0; p < 40; p++)
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send(MODE_PATTERN, pick_sym(), i == len - 1);
        end
        send(MODE_PATTERN, pick_sym(), 1'b0);
        send(MODE_BUILD, 8'h00, 1'b0);
        send(MODE_PATTERN, pick_sym(), 1'b1);
        send(MODE_BUILD, 8'h00, 1'b0);
        for (int n = 0; n < 760; n++)
        begin
            if (n == 600)
                idle_on = 1'b0;
            if ($urandom_range(0, 14) == 0)
                send(MODE_QUERY, pick_sym(), 1'b1);
            else
                send(MODE_QUERY, pick_sym(), $urandom_range(0, 19) == 0);
        end
        send(MODE_QUERY, pick_sym(), 1'b1);
        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("multi_pattern_byte_matcher_tb: PASS");
        else
            $display("multi_pattern_byte_matcher_tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/mpbm_pkg.sv
rtl/mpbm_dp.sv
rtl/mpbm_ctrl.sv
rtl/multi_pattern_byte_matcher.sv
sim/mpbm_checker.sv
sim/multi_pattern_byte_matcher_tb.sv
